// ===== sv/vlpp_pkg.sv =====
// Package for the velocity-limited position planner.
// Shared types, command codes and constants; no dependencies.
package vlpp_pkg;

	localparam int unsigned POS_FRAC_BITS_DEF = 8;
	localparam int unsigned VEL_FRAC_BITS_DEF = 8;

	// Command codes carried by the command field.
	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_MOVE   = 3'd1;
	localparam logic [2:0] CMD_STOP   = 3'd2;
	localparam logic [2:0] CMD_PERIM  = 3'd3;
	localparam logic [2:0] CMD_RESET  = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] REG_PERIOD  = 2'd0;
	localparam logic [1:0] REG_WINDOW  = 2'd1;
	localparam logic [1:0] REG_CPC     = 2'd2;
	localparam logic [1:0] REG_OVERRUN = 2'd3;

	// Register reset values.
	localparam logic [9:0]  PERIOD_RST  = 10'd100;
	localparam logic [11:0] WINDOW_RST  = 12'd128;
	localparam logic [19:0] CPC_RST     = 20'd5000;
	localparam logic [15:0] OVERRUN_RST = 16'd2560;
	localparam logic [6:0]  ACCEL_RST   = 7'd70;

	localparam logic [6:0] ACC_FAST  = 7'd30;
	localparam logic [6:0] ACC_SLOW  = 7'd60;
	localparam logic [6:0] ACC_STOP  = 7'd80;
	localparam logic [6:0] ACC_PFAST = 7'd90;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // latch the beat and start the multiplier
		logic mul2;    // second step: dv product and position
		logic err;     // compute the error and reset the square-root unit
		logic sqrt;    // one square-root step: operand load or iteration
		logic finish;  // update state with the root result
	} vlpp_cmd_t;

	typedef struct packed {
		logic sqrt_done;
	} vlpp_sts_t;

endpackage

// ===== sv/vlpp_if.sv =====
// Valid/ready channel interface for the planner.
// Payload type is a parameter; uses no package.
interface vlpp_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/vlpp_ctrl.sv =====
// Controller state machine of the planner.
// Depends on vlpp_pkg for command and status structs.
module vlpp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output vlpp_pkg::vlpp_cmd_t cmd,
	input  vlpp_pkg::vlpp_sts_t sts
);
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_ERR  = 6'b000100,
		ST_SQRT = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul2 = 1'b1;
				state_d = ST_ERR;
			end
			ST_ERR: begin
				cmd.err = 1'b1;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt = 1'b1;
				if (sts.sqrt_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				in_ready = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d = ST_MUL;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule

// ===== sv/vlpp_dp.sv =====
// Datapath of the planner: position multiply, error, square root, ramp.
// Depends on vlpp_pkg for command structs and constants.
module vlpp_dp #(
	parameter int unsigned POS_FRAC_BITS = vlpp_pkg::POS_FRAC_BITS_DEF,
	parameter int unsigned VEL_FRAC_BITS = vlpp_pkg::VEL_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vlpp_pkg::vlpp_cmd_t cmd,
	output vlpp_pkg::vlpp_sts_t sts,
	input  logic [2:0]          command,
	input  logic signed [31:0]  encoder_count,
	input  logic signed [23:0]  distance_cm,
	input  logic signed [7:0]   speed_pct,
	input  logic signed [15:0]  measured_speed,
	input  logic [9:0]          period_ms,
	input  logic [11:0]         stop_window,
	input  logic [19:0]         cm_per_count,
	input  logic [15:0]         overrun_cm,
	output logic signed [15:0]  speed_cmd,
	output logic                set_speed,
	output logic                stop_motor,
	output logic                moving,
	output logic                idle
);
	localparam int VW = 16 + VEL_FRAC_BITS;   // velocity register width
	localparam int PS = 16 - POS_FRAC_BITS;   // position product shift
	localparam int RW = 64;                   // root operand width
	localparam int RI = RW / 2;               // root iterations
	localparam int CW = $clog2(RI + 1);
	localparam int DVW = 17 + VEL_FRAC_BITS;  // accel*period*2^V fits here

	// Division by 1000 through a reciprocal: the dividend accel*period*2^V has
	// 17+V bits, so a shift of 27+V bits keeps the quotient exact.
	localparam int DIV_SH = 27 + VEL_FRAC_BITS;
	localparam int DIV_MW = DIV_SH - 9;
	localparam logic [DIV_MW-1:0] DIV_M =
		DIV_MW'(((64'd1 << DIV_SH) + 64'd999) / 64'd1000);
	localparam int DIV_PW = DIV_MW + 17;

	// Beat latches.
	logic [2:0]          cmd_q;
	logic signed [23:0]  dist_q;
	logic signed [7:0]   sp_q;
	logic signed [15:0]  meas_q;

	// Planner state.
	logic                idle_q, en_q, fwd_q, bwd_q, act_q;
	logic signed [31:0]  tgt_q;
	logic signed [VW-1:0] vel_q, lim_q;
	logic [6:0]          acc_q;

	// Products and intermediates.
	logic signed [52:0]  prod_q;
	logic [16:0]         dvprod_q;
	logic [DVW-1:0]      dv_q;
	logic signed [31:0]  pos_q;
	logic signed [33:0]  err_q;
	logic [RW-1:0]       rx_q, rr_q, rb_q;
	logic [CW-1:0]       cnt_q;
	logic                set_q, stopm_q;

	// Position: floor(prod >> PS) saturated to 32 bits.
	logic signed [52:0] psh;
	logic signed [31:0] pos_c;
	assign psh = prod_q >>> PS;
	always_comb begin
		if (psh > 53'sd2147483647) pos_c = 32'sh7fffffff;
		else if (psh < -53'sd2147483648) pos_c = 32'sh80000000;
		else pos_c = psh[31:0];
	end

	// Velocity step per tick, taken from the upper bits of the reciprocal product.
	logic [DIV_PW-1:0] dvfull;
	assign dvfull = DIV_PW'(dvprod_q) * DIV_PW'(DIV_M);

	// Q.8 to position scaling.
	function automatic logic signed [40:0] q8pos(input logic signed [24:0] v);
		logic signed [40:0] w;
		w = 41'(v);
		if (POS_FRAC_BITS >= 8) q8pos = w <<< (POS_FRAC_BITS - 8);
		else q8pos = w >>> (8 - POS_FRAC_BITS);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
		if (v > 42'sd2147483647) sat32 = 32'sh7fffffff;
		else if (v < -42'sd2147483648) sat32 = 32'sh80000000;
		else sat32 = v[31:0];
	endfunction

	logic signed [VW-1:0] meas_v;
	always_comb begin
		if (VEL_FRAC_BITS >= 8) meas_v = VW'(meas_q) <<< (VEL_FRAC_BITS - 8);
		else meas_v = VW'(meas_q >>> (8 - VEL_FRAC_BITS));
	end

	localparam logic signed [VW-1:0] P3  = VW'(3) <<< VEL_FRAC_BITS;
	localparam logic signed [VW-1:0] P4  = VW'(4) <<< VEL_FRAC_BITS;
	localparam logic signed [VW-1:0] P40 = VW'(40) <<< VEL_FRAC_BITS;
	localparam logic signed [VW-1:0] P80 = VW'(80) <<< VEL_FRAC_BITS;

	// Root operand from the capped error.
	localparam logic [33:0] CAP = 34'd2048 << POS_FRAC_BITS;
	logic [33:0] eabs, ecap;
	logic [RW-1:0] term, dvsq;
	assign eabs = err_q[33] ? 34'(-err_q) : 34'(err_q);
	assign ecap = (eabs > CAP) ? CAP : eabs;
	always_comb begin
		term = RW'(ecap) * RW'({acc_q, 1'b0});
		if (2 * VEL_FRAC_BITS >= POS_FRAC_BITS) term = term << (2 * VEL_FRAC_BITS - POS_FRAC_BITS);
		else term = term >> (POS_FRAC_BITS - 2 * VEL_FRAC_BITS);
	end
	assign dvsq = RW'(dv_q) * RW'(dv_q);

	// One restoring square-root step.
	logic [RW-1:0] rsum;
	assign rsum = rr_q + rb_q;

	// Ramp and clamp after the root.
	logic signed [VW+1:0] root_s, dvs, req, lim2, cur, nxt;
	always_comb begin
		root_s = (VW+2)'(rr_q);
		dvs = (VW+2)'(dv_q);
		lim2 = (VW+2)'(lim_q);
		cur = (VW+2)'(vel_q);
		req = '0;
		if (en_q) begin
			if (err_q > 34'(q8pos(25'(stop_window))) && fwd_q) req = root_s - dvs;
			else if (err_q < -34'(q8pos(25'(stop_window))) && bwd_q) req = dvs - root_s;
		end
		if (req > lim2) req = lim2;
		else if (req < -lim2) req = -lim2;
		if (req > cur + dvs) nxt = cur + dvs;
		else if (req < cur - dvs) nxt = cur - dvs;
		else nxt = req;
	end

	logic active_req;
	assign active_req = en_q && ((err_q > 34'(q8pos(25'(stop_window))) && fwd_q) ||
		(err_q < -34'(q8pos(25'(stop_window))) && bwd_q));

	assign sts.sqrt_done = (cnt_q == '0);

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			dist_q <= distance_cm;
			sp_q <= speed_pct;
			meas_q <= measured_speed;
			prod_q <= 53'(encoder_count) * 53'($signed({1'b0, cm_per_count}));
			dvprod_q <= 17'(acc_q) * 17'(period_ms);
		end
		if (cmd.mul2) begin
			pos_q <= pos_c;
			dv_q <= DVW'(dvfull >> (DIV_SH - VEL_FRAC_BITS));
		end
		if (cmd.err) begin
			err_q <= 34'(tgt_q) - 34'(pos_q);
		end
	end

	// Square-root unit: RI iterations, one result bit each.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rx_q <= '0; rr_q <= '0; rb_q <= '0;
		end else if (cmd.err) begin
			rx_q <= '0; rr_q <= '0;
			rb_q <= RW'(1) << (RW - 2);
			cnt_q <= CW'(RI + 1);
		end else if (cmd.sqrt && cnt_q == CW'(RI + 1)) begin
			// First step loads the operand, computed from registered error.
			rx_q <= term + dvsq;
			cnt_q <= CW'(RI);
		end else if (cmd.sqrt && cnt_q != '0) begin
			if (rx_q >= rsum) begin
				rx_q <= rx_q - rsum;
				rr_q <= (rr_q >> 1) + rb_q;
			end else begin
				rr_q <= rr_q >> 1;
			end
			rb_q <= rb_q >> 2;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// State update at the end of the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= 1'b1; en_q <= 1'b0; fwd_q <= 1'b0; bwd_q <= 1'b0; act_q <= 1'b0;
			tgt_q <= '0; vel_q <= '0; lim_q <= '0; acc_q <= vlpp_pkg::ACCEL_RST;
			set_q <= 1'b0; stopm_q <= 1'b0;
		end else if (cmd.finish) begin
			set_q <= 1'b0;
			stopm_q <= 1'b0;
			case (cmd_q)
				vlpp_pkg::CMD_TICK: begin
					if (!idle_q) begin
						if (!en_q) tgt_q <= pos_q;
						vel_q <= VW'(nxt);
						set_q <= 1'b1;
						if (active_req || nxt != '0) act_q <= 1'b1;
						else begin
							act_q <= 1'b0;
							en_q <= 1'b0;
							stopm_q <= 1'b1;
							idle_q <= 1'b1;
						end
					end
				end
				vlpp_pkg::CMD_MOVE: begin
					idle_q <= 1'b0;
					en_q <= 1'b1;
					tgt_q <= sat32(42'(pos_q) + 42'(q8pos(25'(dist_q))));
					fwd_q <= !dist_q[23];
					bwd_q <= dist_q[23];
					if (meas_v < P4 && meas_v > -P4) vel_q <= dist_q[23] ? -P3 : P3;
					else vel_q <= meas_v;
					lim_q <= (sp_q[7] ? -VW'(sp_q) : VW'(sp_q)) <<< VEL_FRAC_BITS;
					acc_q <= ((sp_q[7] ? -VW'(sp_q) : VW'(sp_q)) > VW'(70)) ?
						vlpp_pkg::ACC_FAST : vlpp_pkg::ACC_SLOW;
				end
				vlpp_pkg::CMD_STOP: begin
					acc_q <= vlpp_pkg::ACC_STOP;
					en_q <= 1'b0;
					vel_q <= meas_v;
					lim_q <= meas_v[VW-1] ? -meas_v : meas_v;
					if ((meas_v[VW-1] ? -meas_v : meas_v) < P4) begin
						stopm_q <= 1'b1;
						act_q <= 1'b0;
						idle_q <= 1'b1;
					end else begin
						idle_q <= 1'b0;
					end
				end
				vlpp_pkg::CMD_PERIM: begin
					vel_q <= meas_v[VW-1] ? '0 : meas_v;
					idle_q <= 1'b0;
					acc_q <= (meas_v > P80) ? vlpp_pkg::ACC_PFAST : vlpp_pkg::ACC_STOP;
					en_q <= 1'b1;
					fwd_q <= 1'b1;
					bwd_q <= 1'b0;
					tgt_q <= sat32(42'(pos_q) + 42'(q8pos(25'({1'b0, overrun_cm}))));
					lim_q <= (meas_v < P40) ? P40 : meas_v;
				end
				vlpp_pkg::CMD_RESET: begin
					en_q <= 1'b0;
					act_q <= 1'b0;
					idle_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Output conversion to Q8.8 with saturation.
	logic signed [VW-1:0] q8v;
	always_comb begin
		if (VEL_FRAC_BITS >= 8) q8v = vel_q >>> (VEL_FRAC_BITS - 8);
		else q8v = vel_q <<< (8 - VEL_FRAC_BITS);
		if (q8v > VW'(32767)) speed_cmd = 16'sh7fff;
		else if (q8v < -VW'(32768)) speed_cmd = 16'sh8000;
		else speed_cmd = q8v[15:0];
	end
	assign set_speed = set_q;
	assign stop_motor = stopm_q;
	assign moving = act_q;
	assign idle = idle_q;
endmodule

// ===== sv/velocity_limited_position_planner.sv =====
// Top level of the velocity-limited position planner.
// Depends on vlpp_pkg, vlpp_if, vlpp_ctrl and vlpp_dp.
//
// Channel   Dir   Payload
// in_ch     sink  command, encoder_count, distance_cm, speed_pct, measured_speed
// out_ch    src   speed_cmd, set_speed, stop_motor, moving, idle
// apb       sink  period_ms, stop_window, cm_per_count, overrun_cm
//
// Each beat passes these steps from input acceptance to the earliest result
// acceptance: multiply, error, a step that loads the root operand, 32
// square-root iterations of one bit each, a done step, finish, then the
// result beat. The square-root unit sets the rate. Reset is asynchronous and
// active low. While a result is stalled, the next input beat is accepted in
// the same cycle the result leaves.
module velocity_limited_position_planner #(
	parameter int unsigned POS_FRAC_BITS = vlpp_pkg::POS_FRAC_BITS_DEF,
	parameter int unsigned VEL_FRAC_BITS = vlpp_pkg::VEL_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	vlpp_if.sink        in_ch,
	vlpp_if.source      out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [9:0]  period_q;
	logic [11:0] window_q;
	logic [19:0] cpc_q;
	logic [15:0] overrun_q;

	// Register file: register i sits at byte address 4*i.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= vlpp_pkg::PERIOD_RST;
			window_q <= vlpp_pkg::WINDOW_RST;
			cpc_q <= vlpp_pkg::CPC_RST;
			overrun_q <= vlpp_pkg::OVERRUN_RST;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			unique case (paddr[3:2])
				vlpp_pkg::REG_PERIOD:  period_q <= pwdata[9:0];
				vlpp_pkg::REG_WINDOW:  window_q <= pwdata[11:0];
				vlpp_pkg::REG_CPC:     cpc_q <= pwdata[19:0];
				vlpp_pkg::REG_OVERRUN: overrun_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr[3:2])
			vlpp_pkg::REG_PERIOD:  prdata = 32'(period_q);
			vlpp_pkg::REG_WINDOW:  prdata = 32'(window_q);
			vlpp_pkg::REG_CPC:     prdata = 32'(cpc_q);
			vlpp_pkg::REG_OVERRUN: prdata = 32'(overrun_q);
			default: prdata = '0;
		endcase
	end

	vlpp_pkg::vlpp_cmd_t cmd;
	vlpp_pkg::vlpp_sts_t sts;

	vlpp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .sts(sts)
	);

	vlpp_dp #(.POS_FRAC_BITS(POS_FRAC_BITS), .VEL_FRAC_BITS(VEL_FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.command(in_ch.data.command),
		.encoder_count(in_ch.data.encoder_count),
		.distance_cm(in_ch.data.distance_cm),
		.speed_pct(in_ch.data.speed_pct),
		.measured_speed(in_ch.data.measured_speed),
		.period_ms(period_q), .stop_window(window_q),
		.cm_per_count(cpc_q), .overrun_cm(overrun_q),
		.speed_cmd(out_ch.data.speed_cmd),
		.set_speed(out_ch.data.set_speed),
		.stop_motor(out_ch.data.stop_motor),
		.moving(out_ch.data.moving),
		.idle(out_ch.data.idle)
	);

	// A beat is only loaded when the controller offers ready.
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> in_ch.ready) else $error("load without ready");
	// No input is taken while a computation is in flight.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sqrt |-> !in_ch.ready) else $error("ready during root");
	// A result never appears in the cycle right after a load.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !out_ch.valid) else $error("result too early");
endmodule
